>>> src/gpe_pkg.sv
// Shared types, register codes, limits and the arctangent table of the phasor estimator.
package gpe_pkg;

  // Input sample set
  typedef struct packed {
    logic signed [31:0] sample_0;
    logic signed [31:0] sample_1;
    logic signed [31:0] sample_2;
    logic signed [31:0] sample_3;
    logic signed [31:0] sample_4;
    logic signed [31:0] sample_5;
    logic signed [31:0] sample_6;
    logic signed [31:0] sample_7;
    logic [7:0]         channels_present;
    logic [63:0]        sample_time;
  } gpe_in_t;

  // One phasor result
  typedef struct packed {
    logic [2:0]         channel_index;
    logic [39:0]        magnitude;
    logic signed [15:0] angle;
    logic [63:0]        result_time;
    logic [8:0]         window_used;
    logic               last_channel;
  } gpe_out_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_WINDOW   = 3'd0,
    CFG_CHANNELS = 3'd1,
    CFG_COS      = 3'd2,
    CFG_SIN      = 3'd3,
    CFG_SCALE    = 3'd4
  } gpe_cfg_e;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ACC_LO,
    ST_ACC_HI,
    ST_ACC_UPD,
    ST_STEP_END,
    ST_E_CLO,
    ST_E_CHI,
    ST_E_SLO,
    ST_E_SHI,
    ST_E_SUPD,
    ST_NORM,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_SQRT,
    ST_MS1,
    ST_MS2,
    ST_MS3,
    ST_EMIT
  } gpe_state_e;

  localparam int unsigned SAMPLE_FIELDS = 8;
  localparam int unsigned CORDIC_STEPS  = 20;

  localparam logic [8:0]         WINDOW_RST   = 9'd80;
  localparam logic [3:0]         CHANNELS_RST = 4'd8;
  localparam logic [31:0]        COS_RST      = 32'd1070431821;
  localparam logic [31:0]        SIN_RST      = 32'd84244817;
  localparam logic [33:0]        SCALE_RST    = 34'd107374182;

  localparam logic signed [63:0] ACC_LIMIT    = 64'sd2305843009213693952;
  localparam logic signed [31:0] Q30_LIMIT    = 32'sd1073741824;
  localparam logic [33:0]        SCALE_LIMIT  = 34'd8589934592;
  localparam logic [39:0]        MAG_MAX      = 40'hFF_FFFF_FFFF;
  localparam logic signed [23:0] QUARTER_TURN = 24'sd2304000;
  localparam logic signed [15:0] HALF_TURN    = 16'sd18000;

  // Arctangent of 2^-i in units of 1/25600 degree
  function automatic logic [20:0] atan_entry(input logic [4:0] idx);
    logic [20:0] v;
    case (idx)
      5'd0:  v = 21'd1152000;
      5'd1:  v = 21'd680065;
      5'd2:  v = 21'd359328;
      5'd3:  v = 21'd182400;
      5'd4:  v = 21'd91554;
      5'd5:  v = 21'd45822;
      5'd6:  v = 21'd22916;
      5'd7:  v = 21'd11459;
      5'd8:  v = 21'd5730;
      5'd9:  v = 21'd2865;
      5'd10: v = 21'd1432;
      5'd11: v = 21'd716;
      5'd12: v = 21'd358;
      5'd13: v = 21'd179;
      5'd14: v = 21'd90;
      5'd15: v = 21'd45;
      5'd16: v = 21'd22;
      5'd17: v = 21'd11;
      5'd18: v = 21'd6;
      5'd19: v = 21'd3;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/gpe_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
module gpe_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  // Register the product; the result is valid in the cycle after the operands
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> src/gpe_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
module gpe_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] v_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic [63:0] rem_q, res_q, bit_q;
  logic [63:0] trial;

  assign trial  = res_q + bit_q;
  assign busy_o = (bit_q != 64'd0);
  assign root_o = res_q[31:0];

  // Load on start, then settle one bit pair per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      res_q <= '0;
      bit_q <= '0;
    end else if (start_i) begin
      rem_q <= v_i;
      res_q <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_o) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

>>> src/gpe_cordic.sv
// Iterative CORDIC vectoring unit: one rotation step per cycle, angle accumulates in z.
module gpe_cordic import gpe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [29:0]        x_i,
  input  logic [29:0]        y_i,
  output logic               busy_o,
  output logic signed [23:0] z_o
);

  logic signed [33:0] x_q, y_q, dx, dy;
  logic signed [23:0] z_q, da;
  logic [4:0]         i_q;
  logic               run_q;

  assign dx     = y_q >>> i_q;
  assign dy     = x_q >>> i_q;
  assign da     = signed'({3'b000, atan_entry(i_q)});
  assign busy_o = run_q;
  assign z_o    = z_q;

  // Rotate toward the x axis until all steps are done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      z_q   <= '0;
      i_q   <= '0;
      run_q <= 1'b0;
    end else if (start_i) begin
      x_q   <= signed'({4'b0000, x_i});
      y_q   <= signed'({4'b0000, y_i});
      z_q   <= '0;
      i_q   <= '0;
      run_q <= 1'b1;
    end else if (run_q) begin
      if (y_q > 34'sd0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + da;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - da;
      end
      i_q <= i_q + 5'd1;
      if (i_q == 5'(CORDIC_STEPS - 1)) begin
        run_q <= 1'b0;
      end
    end
  end

endmodule

>>> src/goertzel_phasor_estimator.sv
// Top level: Goertzel bin-1 phasor estimator with a shared multiplier, square root and CORDIC.
//
// Usage: sample sets enter on the input channel (in_valid_i, in_stall_o, in_data_i) and are
// taken when valid is high and stall is low. Results leave on the output channel (out_valid_o,
// out_stall_i, out_data_o), one per channel in use, in ascending channel order, the last of a
// window flagged by last_channel. Registers are written through cfg_valid_i / cfg_index_i /
// cfg_data_i, always ready; write them only while the block is idle.
// Flow: every sample set walks all CHANNELS accumulators through one shared 32x32
// multiplier, in states ACC_LO, ACC_HI and ACC_UPD per channel in use and ACC_LO alone per
// idle channel, then STEP_END. The sample that closes a window then takes each channel in
// use through four multiplier passes for the phasor, a normalizing shift of one bit per
// cycle, two squarings, a 32-step square root (the 20-step CORDIC runs alongside it) and two
// scaling passes. The input stays stalled until all work of an item is done and its last
// result sits in the output register.
// Reset clears accumulators, the sample position and the output valid flag and loads the
// register defaults. A stalled output holds its result; a result waiting there does not keep
// the block from taking the next sample set, only a further result waits for the slot.
module goertzel_phasor_estimator import gpe_pkg::*; #(
  parameter int CHANNELS   = 8,
  parameter int MAX_WINDOW = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  gpe_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output gpe_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [33:0] cfg_data_i
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Round a split product a*c / 2^sh half away from zero and saturate
  function automatic logic signed [63:0] mulq_fin(input logic [63:0] lo, input logic [63:0] hi,
                                                  input logic sh29, input logic neg);
    logic [64:0] r;
    logic [65:0] m;
    if (sh29) begin
      r = {1'b0, lo} + 65'd268435456;
      m = (66'(hi) << 3) + 66'(r >> 29);
    end else begin
      r = {1'b0, lo} + 65'd536870912;
      m = (66'(hi) << 2) + 66'(r >> 30);
    end
    if (m > 66'(ACC_LIMIT)) begin
      m = 66'(ACC_LIMIT);
    end
    return neg ? -signed'(m[63:0]) : signed'(m[63:0]);
  endfunction

  function automatic logic signed [63:0] clamp_acc(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > ACC_LIMIT) begin
      r = ACC_LIMIT;
    end else if (v < -ACC_LIMIT) begin
      r = -ACC_LIMIT;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [31:0] clamp_coef(input logic [31:0] raw);
    logic signed [31:0] r;
    r = signed'(raw);
    if (r > Q30_LIMIT) begin
      r = Q30_LIMIT;
    end else if (r < -Q30_LIMIT) begin
      r = -Q30_LIMIT;
    end
    return r;
  endfunction

  // Configuration registers
  logic [8:0]  win_cfg_q;
  logic [3:0]  chn_cfg_q;
  logic [31:0] cos_cfg_q, sin_cfg_q;
  logic [33:0] scl_cfg_q;

  // Sequencer and datapath registers
  gpe_state_e           state_q, state_d;
  logic [CH_W-1:0]      ch_q;
  logic [8:0]           pos_q;
  gpe_in_t              item_q;
  logic signed [63:0]   rec_q [CHANNELS];
  logic signed [63:0]   old_q [CHANNELS];
  logic [63:0]          plo_q;
  logic signed [63:0]   re_q;
  logic                 re_neg_q, im_neg_q, zero_q;
  logic [63:0]          ux_q, uy_q;
  logic signed [6:0]    e_q;
  logic [39:0]          mag_q;
  gpe_out_t             out_q;
  logic                 out_valid_q;

  // Derived values
  logic [8:0]           win_eff;
  logic [3:0]           used;
  logic signed [31:0]   coef_c, coef_s;
  logic [31:0]          cm_c, cm_s;
  logic [33:0]          scale_eff;
  logic [3:0]           ch_ext;
  logic                 ch_last, ch_skip, last_used;
  logic signed [63:0]   x_smp, s1, s2, mq_acc, mq_c, mq_s;
  logic [63:0]          am_s1, am_s2, m_max, prod, p_full;
  logic [8:0]           pos_nx;
  logic                 win_end;
  logic [31:0]          mul_a, mul_b;
  logic                 sq_start, cd_start, sq_busy, cd_busy, out_load;
  logic [31:0]          root;
  logic signed [23:0]   cd_z, z_clip;
  logic signed [6:0]    net;
  logic [5:0]           rsh;
  logic [72:0]          wide;
  logic [64:0]          rnd;
  logic [39:0]          mag_calc;
  logic signed [15:0]   ang_calc;
  logic [14:0]          ang_abs;

  assign cfg_ready_o = 1'b1;

  // Effective settings
  always_comb begin
    if (win_cfg_q == 9'd0) begin
      win_eff = 9'd1;
    end else if (int'(win_cfg_q) > MAX_WINDOW) begin
      win_eff = 9'(MAX_WINDOW);
    end else begin
      win_eff = win_cfg_q;
    end
    used      = (int'(chn_cfg_q) > CHANNELS) ? 4'(CHANNELS) : chn_cfg_q;
    coef_c    = clamp_coef(cos_cfg_q);
    coef_s    = clamp_coef(sin_cfg_q);
    scale_eff = (scl_cfg_q > SCALE_LIMIT) ? SCALE_LIMIT : scl_cfg_q;
  end

  assign cm_c      = 32'(abs64(64'(coef_c)));
  assign cm_s      = 32'(abs64(64'(coef_s)));
  assign ch_ext    = 4'(ch_q);
  assign ch_last   = (ch_q == CH_W'(CHANNELS - 1));
  assign ch_skip   = (ch_ext >= used);
  assign last_used = ((ch_ext + 4'd1) == used);
  assign s1        = rec_q[ch_q];
  assign s2        = old_q[ch_q];
  assign am_s1     = abs64(s1);
  assign am_s2     = abs64(s2);
  assign pos_nx    = pos_q + 9'd1;
  assign win_end   = (pos_nx >= win_eff);
  assign m_max     = (ux_q > uy_q) ? ux_q : uy_q;

  // Pick this channel's sample, zero beyond the carried count
  always_comb begin
    x_smp = '0;
    if ((ch_ext < 4'(SAMPLE_FIELDS)) && ({4'b0000, ch_ext} < item_q.channels_present)) begin
      case (ch_ext[2:0])
        3'd0:    x_smp = 64'(item_q.sample_0);
        3'd1:    x_smp = 64'(item_q.sample_1);
        3'd2:    x_smp = 64'(item_q.sample_2);
        3'd3:    x_smp = 64'(item_q.sample_3);
        3'd4:    x_smp = 64'(item_q.sample_4);
        3'd5:    x_smp = 64'(item_q.sample_5);
        3'd6:    x_smp = 64'(item_q.sample_6);
        3'd7:    x_smp = 64'(item_q.sample_7);
        default: x_smp = '0;
      endcase
    end
  end

  // Finish the split products
  assign mq_acc = mulq_fin(plo_q, prod, 1'b1, s1[63] ^ coef_c[31]);
  assign mq_c   = mulq_fin(plo_q, prod, 1'b0, s2[63] ^ coef_c[31]);
  assign mq_s   = mulq_fin(plo_q, prod, 1'b0, s2[63] ^ coef_s[31]);

  gpe_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  gpe_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .v_i     (plo_q + prod),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

  gpe_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cd_start),
    .x_i     (ux_q[29:0]),
    .y_i     (uy_q[29:0]),
    .busy_o  (cd_busy),
    .z_o     (cd_z)
  );

  // Scale the root and round or saturate into Q32.8
  assign p_full = plo_q + {prod[31:0], 32'd0};
  assign net    = e_q - 7'sd24;
  assign rsh    = 6'(-net);
  always_comb begin
    wide     = 73'(p_full) << net[3:0];
    rnd      = ({1'b0, p_full} + (65'd1 << (rsh - 6'd1))) >> rsh;
    mag_calc = '0;
    if (!net[6]) begin
      mag_calc = (wide > 73'(MAG_MAX)) ? MAG_MAX : wide[39:0];
    end else begin
      mag_calc = (rnd > 65'(MAG_MAX)) ? MAG_MAX : rnd[39:0];
    end
  end

  // Map the first-quadrant angle to the quadrant of the phasor
  always_comb begin
    if (cd_z < 24'sd0) begin
      z_clip = '0;
    end else if (cd_z > QUARTER_TURN) begin
      z_clip = QUARTER_TURN;
    end else begin
      z_clip = cd_z;
    end
    ang_abs  = 15'((z_clip + 24'sd128) >>> 8);
    ang_calc = signed'({1'b0, ang_abs});
    if (re_neg_q) begin
      ang_calc = HALF_TURN - ang_calc;
    end
    if (im_neg_q) begin
      ang_calc = -ang_calc;
    end
    if (zero_q) begin
      ang_calc = '0;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_ACC_LO;
      ST_ACC_LO: begin
        if (ch_skip) begin
          state_d = ch_last ? ST_STEP_END : ST_ACC_LO;
        end else begin
          state_d = ST_ACC_HI;
        end
      end
      ST_ACC_HI:   state_d = ST_ACC_UPD;
      ST_ACC_UPD:  state_d = ch_last ? ST_STEP_END : ST_ACC_LO;
      ST_STEP_END: state_d = (win_end && (used != 4'd0)) ? ST_E_CLO : ST_IDLE;
      ST_E_CLO:    state_d = ST_E_CHI;
      ST_E_CHI:    state_d = ST_E_SLO;
      ST_E_SLO:    state_d = ST_E_SHI;
      ST_E_SHI:    state_d = ST_E_SUPD;
      ST_E_SUPD:   state_d = ((re_q == 64'sd0) && (mq_s == 64'sd0)) ? ST_EMIT : ST_NORM;
      ST_NORM: begin
        if ((m_max[63:30] == '0) && m_max[29]) begin
          state_d = ST_SQ1;
        end
      end
      ST_SQ1:      state_d = ST_SQ2;
      ST_SQ2:      state_d = ST_SQ3;
      ST_SQ3:      state_d = ST_SQRT;
      ST_SQRT:     if (!sq_busy && !cd_busy) state_d = ST_MS1;
      ST_MS1:      state_d = ST_MS2;
      ST_MS2:      state_d = ST_MS3;
      ST_MS3:      state_d = ST_EMIT;
      ST_EMIT:     if (out_load) state_d = last_used ? ST_IDLE : ST_E_CLO;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands, unit starts, handshakes
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    sq_start = 1'b0;
    cd_start = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_ACC_LO: begin
        mul_a = am_s1[31:0];
        mul_b = cm_c;
      end
      ST_ACC_HI: begin
        mul_a = {2'b00, am_s1[61:32]};
        mul_b = cm_c;
      end
      ST_E_CLO: begin
        mul_a = am_s2[31:0];
        mul_b = cm_c;
      end
      ST_E_CHI: begin
        mul_a = {2'b00, am_s2[61:32]};
        mul_b = cm_c;
      end
      ST_E_SLO: begin
        mul_a = am_s2[31:0];
        mul_b = cm_s;
      end
      ST_E_SHI: begin
        mul_a = {2'b00, am_s2[61:32]};
        mul_b = cm_s;
      end
      ST_SQ1: begin
        mul_a = ux_q[31:0];
        mul_b = ux_q[31:0];
      end
      ST_SQ2: begin
        mul_a = uy_q[31:0];
        mul_b = uy_q[31:0];
      end
      ST_SQ3: begin
        sq_start = 1'b1;
        cd_start = 1'b1;
      end
      ST_MS1: begin
        mul_a = root;
        mul_b = scale_eff[31:0];
      end
      ST_MS2: begin
        mul_a = root;
        mul_b = {30'd0, scale_eff[33:32]};
      end
      ST_EMIT: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q <= WINDOW_RST;
      chn_cfg_q <= CHANNELS_RST;
      cos_cfg_q <= COS_RST;
      sin_cfg_q <= SIN_RST;
      scl_cfg_q <= SCALE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WINDOW:   win_cfg_q <= cfg_data_i[8:0];
        CFG_CHANNELS: chn_cfg_q <= cfg_data_i[3:0];
        CFG_COS:      cos_cfg_q <= cfg_data_i[31:0];
        CFG_SIN:      sin_cfg_q <= cfg_data_i[31:0];
        CFG_SCALE:    scl_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        rec_q[i] <= '0;
        old_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: if (in_valid_i) ch_q <= '0;
        ST_ACC_LO: begin
          if (ch_skip) begin
            rec_q[ch_q] <= '0;
            old_q[ch_q] <= '0;
            ch_q        <= ch_last ? '0 : ch_q + CH_W'(1);
          end
        end
        ST_ACC_UPD: begin
          old_q[ch_q] <= s1;
          rec_q[ch_q] <= clamp_acc(x_smp + mq_acc - s2);
          ch_q        <= ch_last ? '0 : ch_q + CH_W'(1);
        end
        ST_STEP_END: begin
          if (win_end) begin
            pos_q <= '0;
            ch_q  <= '0;
            if (used == 4'd0) begin
              for (int i = 0; i < CHANNELS; i++) begin
                rec_q[i] <= '0;
                old_q[i] <= '0;
              end
            end
          end else begin
            pos_q <= pos_nx;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            if (last_used) begin
              for (int i = 0; i < CHANNELS; i++) begin
                rec_q[i] <= '0;
                old_q[i] <= '0;
              end
            end else begin
              ch_q <= ch_q + CH_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (in_valid_i) item_q <= in_data_i;
      ST_ACC_HI, ST_E_CHI, ST_E_SHI, ST_SQ2, ST_MS2: plo_q <= prod;
      ST_E_SLO: re_q <= s1 - mq_c;
      ST_E_SUPD: begin
        re_neg_q <= re_q[63];
        im_neg_q <= mq_s[63];
        ux_q     <= abs64(re_q);
        uy_q     <= abs64(mq_s);
        e_q      <= '0;
        zero_q   <= (re_q == 64'sd0) && (mq_s == 64'sd0);
        mag_q    <= '0;
      end
      ST_NORM: begin
        if (m_max[63:30] != '0) begin
          ux_q <= ux_q >> 1;
          uy_q <= uy_q >> 1;
          e_q  <= e_q + 7'sd1;
        end else if (!m_max[29]) begin
          ux_q <= ux_q << 1;
          uy_q <= uy_q << 1;
          e_q  <= e_q - 7'sd1;
        end
      end
      ST_MS3: mag_q <= mag_calc;
      ST_EMIT: begin
        if (out_load) begin
          out_q.channel_index <= ch_ext[2:0];
          out_q.magnitude     <= mag_q;
          out_q.angle         <= ang_calc;
          out_q.result_time   <= item_q.sample_time;
          out_q.window_used   <= win_eff;
          out_q.last_channel  <= last_used;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> src/gpe_checker.sv
// Port-level checks of the phasor estimator and their bind to the top level.
module gpe_checker import gpe_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input gpe_out_t    out_data_o
);

  // A taken request keeps the input stalled while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a request was taken");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Angle stays within a half turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.angle <= 16'sd18000) && (out_data_o.angle >= -16'sd18000))
    else $error("angle out of range");

  // Window length reported is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.window_used != 9'd0)
    else $error("zero window length reported");

endmodule

bind goertzel_phasor_estimator gpe_checker u_gpe_checker (.*);

>>> tb/tb_goertzel_phasor_estimator.sv
// Self-checking testbench for the Goertzel bin-1 phasor estimator.
`timescale 1ns / 1ps

module tb_goertzel_phasor_estimator;
  import gpe_pkg::*;

  localparam int  NUM_CH      = 8;
  localparam int  WIN_MAX     = 256;
  localparam int  RANDOM_SETS = 420;
  localparam int  SETTLE      = 200;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam longint SAT_61   = 64'sd2305843009213693952;
  localparam longint Q30_ONE  = 64'sd1073741824;
  localparam longint unsigned SCALE_SAT = 64'd8589934592;
  localparam longint unsigned MAG_SAT   = 64'hFF_FFFF_FFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  gpe_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  gpe_out_t    out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [33:0] cfg_data_i;

  goertzel_phasor_estimator uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // Shadow registers and accumulator state
  logic [8:0]         window_reg;
  logic [3:0]         chan_reg;
  logic signed [31:0] cos_reg;
  logic signed [31:0] sin_reg;
  logic [33:0]        scale_reg;
  longint             recent_acc [NUM_CH];
  longint             older_acc  [NUM_CH];
  logic [8:0]         position;

  gpe_out_t expected_phasors[$];
  int       mismatches;
  int       phasors_seen;
  int       sets_sent;
  int       windows_closed;
  bit       no_gaps;
  longint   cycles;

  localparam longint ATAN_STEP [20] = '{1152000, 680065, 359328, 182400, 91554, 45822,
    22916, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3};

  // Clock and cycle guard
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d phasors pending", cycles,
               expected_phasors.size());
      $display("FAIL goertzel_phasor_estimator");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (no_gaps) return 0;
    return $urandom_range(0, 6);
  endfunction

  // Round a*q / 2^sh half away from zero, saturate at 2^61
  function automatic longint coef_product(longint a, longint q, int sh);
    logic [127:0] am, qm, prod;
    bit neg;
    neg  = (a < 0) != (q < 0);
    am   = (a < 0) ? -a : a;
    qm   = (q < 0) ? -q : q;
    prod = (am * qm + (128'd1 << (sh - 1))) >> sh;
    if (prod > SAT_61) prod = SAT_61;
    return neg ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic longint clamp_coef(logic signed [31:0] r);
    longint v;
    v = r;
    if (v > Q30_ONE) v = Q30_ONE;
    if (v < -Q30_ONE) v = -Q30_ONE;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Magnitude and angle of one phasor
  task automatic phasor_of(input longint re, input longint im, input longint unsigned scale,
                           output logic [39:0] mag, output logic signed [15:0] ang);
    longint unsigned ux, uy, m, p;
    longint x, y, z, dx, dy, a;
    int e, net;
    ux = (re < 0) ? -re : re;
    uy = (im < 0) ? -im : im;
    m  = (ux > uy) ? ux : uy;
    e  = 0;
    if (m == 0) begin
      mag = '0;
      ang = '0;
      return;
    end
    while (m >= (64'd1 << 30)) begin m >>= 1; e++; end
    while (m < (64'd1 << 29)) begin m <<= 1; e--; end
    if (e >= 0) begin
      ux >>= e; uy >>= e;
    end else begin
      ux <<= -e; uy <<= -e;
    end
    p   = floor_sqrt(ux * ux + uy * uy) * scale;
    net = e - 24;
    if (net >= 0) begin
      p = (p > (MAG_SAT >> net)) ? MAG_SAT : (p << net);
    end else begin
      p = (p + (64'd1 << (-net - 1))) >> (-net);
      if (p > MAG_SAT) p = MAG_SAT;
    end
    mag = p[39:0];
    x = ux; y = uy; z = 0;
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_STEP[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_STEP[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 2304000) z = 2304000;
    a = (z + 128) >>> 8;
    if (re < 0) a = 18000 - a;
    if (im < 0) a = -a;
    ang = a[15:0];
  endtask

  function automatic longint sample_of(gpe_in_t s, int ch);
    case (ch)
      0: return s.sample_0;
      1: return s.sample_1;
      2: return s.sample_2;
      3: return s.sample_3;
      4: return s.sample_4;
      5: return s.sample_5;
      6: return s.sample_6;
      default: return s.sample_7;
    endcase
  endfunction

  // Advance the recurrence for one sample set; queue phasors when the window closes
  task automatic goertzel_advance(input gpe_in_t s);
    int win, used;
    longint c, sn, x, s0, re, im;
    gpe_out_t r;
    win  = (window_reg == 0) ? 1 : ((window_reg > WIN_MAX) ? WIN_MAX : window_reg);
    used = (chan_reg > NUM_CH) ? NUM_CH : chan_reg;
    c    = clamp_coef(cos_reg);
    sn   = clamp_coef(sin_reg);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (ch >= used) begin
        recent_acc[ch] = 0;
        older_acc[ch]  = 0;
      end else begin
        x  = (ch < s.channels_present) ? sample_of(s, ch) : 0;
        s0 = x + coef_product(recent_acc[ch], c, 29) - older_acc[ch];
        if (s0 > SAT_61) s0 = SAT_61;
        if (s0 < -SAT_61) s0 = -SAT_61;
        older_acc[ch]  = recent_acc[ch];
        recent_acc[ch] = s0;
      end
    end
    position = position + 9'd1;
    if (position < win) return;
    windows_closed++;
    for (int ch = 0; ch < used; ch++) begin
      re = recent_acc[ch] - coef_product(older_acc[ch], c, 30);
      im = coef_product(older_acc[ch], sn, 30);
      phasor_of(re, im, (scale_reg > SCALE_SAT) ? SCALE_SAT : scale_reg,
                r.magnitude, r.angle);
      r.channel_index = ch[2:0];
      r.result_time   = s.sample_time;
      r.window_used   = win[8:0];
      r.last_channel  = (ch + 1 == used);
      expected_phasors.push_back(r);
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      recent_acc[ch] = 0;
      older_acc[ch]  = 0;
    end
    position = '0;
  endtask

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("mismatch on %s at cycle %0d: got %0h, want %0h", field, cycles, got, want);
  endtask

  // Check each accepted phasor against the oldest prediction
  always @(posedge clk_i) begin
    gpe_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      phasors_seen++;
      if (expected_phasors.size() == 0) begin
        report_mismatch("unexpected phasor", out_data_o.channel_index, 0);
      end else begin
        want = expected_phasors.pop_front();
        if (out_data_o.channel_index !== want.channel_index)
          report_mismatch("channel_index", out_data_o.channel_index, want.channel_index);
        if (out_data_o.magnitude !== want.magnitude)
          report_mismatch("magnitude", out_data_o.magnitude, want.magnitude);
        if (out_data_o.angle !== want.angle)
          report_mismatch("angle", out_data_o.angle, want.angle);
        if (out_data_o.result_time !== want.result_time)
          report_mismatch("result_time", out_data_o.result_time, want.result_time);
        if (out_data_o.window_used !== want.window_used)
          report_mismatch("window_used", out_data_o.window_used, want.window_used);
        if (out_data_o.last_channel !== want.last_channel)
          report_mismatch("last_channel", out_data_o.last_channel, want.last_channel);
      end
    end
  end

  // Output back-pressure: stall a random count, then take one phasor
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Send one sample set, predicting on acceptance; valid stays high afterwards
  task automatic send_set(input gpe_in_t s);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
    goertzel_advance(s);
    sets_sent++;
  endtask

  // Write one register, then drop valid before returning
  task automatic write_reg(input gpe_cfg_e idx, input logic [33:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WINDOW:   window_reg = value[8:0];
      CFG_CHANNELS: chan_reg   = value[3:0];
      CFG_COS:      cos_reg    = value[31:0];
      CFG_SIN:      sin_reg    = value[31:0];
      default:      scale_reg  = value;
    endcase
    @(posedge clk_i);
  endtask

  // Drop valid, wait for every predicted phasor, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_phasors.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_all(input logic [8:0] win, input logic [3:0] chans,
                           input logic [31:0] c, input logic [31:0] sn, input logic [33:0] sc);
    write_reg(CFG_WINDOW, 34'(win));
    write_reg(CFG_CHANNELS, 34'(chans));
    write_reg(CFG_COS, 34'(c));
    write_reg(CFG_SIN, 34'(sn));
    write_reg(CFG_SCALE, sc);
  endtask

  function automatic gpe_in_t make_set(int mode, logic [7:0] present);
    gpe_in_t s;
    logic [31:0] v [8];
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: v[i] = $urandom_range(0, 2000) - 1000;
        1: v[i] = $urandom;
        2: v[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: v[i] = $urandom_range(0, 200000) - 100000;
      endcase
    end
    s = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], present, {$urandom, $urandom}};
    return s;
  endfunction

  // One window per item at full scale: extremes, zero phasor, nothing present
  task automatic test_window_of_one();
    write_all(9'd1, 4'd8, COS_RST, SIN_RST, SCALE_RST);
    send_set(make_set(2, 8'd8));
    send_set(make_set(1, 8'd255));
    send_set({256'd0, 8'd8, 64'hFFFF_FFFF_FFFF_FFFF});
    send_set(make_set(1, 8'd0));
    send_set({{8{32'h7FFF_FFFF}}, 8'd8, 64'd0});
    drain();
  endtask

  // Out-of-range registers: zero and oversize window, too many and zero channels, saturated terms
  task automatic test_register_limits();
    write_all(9'd0, 4'd15, 32'h8000_0000, 32'h7FFF_FFFF, 34'h3_FFFF_FFFF);
    send_set(make_set(2, 8'd8));
    send_set({{8{32'h8000_0000}}, 8'd8, 64'd5});
    drain();
    write_all(9'd511, 4'd8, 32'h4000_0000, 32'hC000_0000, 34'h2_0000_0000);
    for (int i = 0; i < 4; i++) send_set(make_set(1, 8'd8));
    drain();
    write_all(9'd2, 4'd0, COS_RST, SIN_RST, SCALE_RST);
    for (int i = 0; i < 4; i++) send_set(make_set(1, 8'd8));
    drain();
  endtask

  // Shorten the window mid-way; the next set must close it
  task automatic test_window_cut_short();
    write_all(9'd8, 4'd3, COS_RST, SIN_RST, SCALE_RST);
    send_set(make_set(3, 8'd2));
    send_set(make_set(3, 8'd255));
    send_set(make_set(3, 8'd3));
    drain();
    write_reg(CFG_WINDOW, 34'd2);
    send_set(make_set(3, 8'd3));
    drain();
  endtask

  // Random configurations with whole windows of random content, at times with extra sets
  task automatic test_random_windows();
    int phase, win, nsets, mode;
    logic [3:0]  chans;
    logic [31:0] c, sn;
    logic [33:0] sc;
    phase = 0;
    while (sets_sent < RANDOM_SETS) begin
      no_gaps = (phase % 4 == 1);
      if (phase == 3) begin
        win = 300;
      end else if ($urandom_range(0, 3) != 0) begin
        win = $urandom_range(1, 6);
      end else begin
        win = $urandom_range(7, 40);
      end
      chans = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 8));
      if ($urandom_range(0, 1)) begin
        c  = $urandom_range(0, 2147483647) - 1073741824;
        sn = $urandom_range(0, 2147483647) - 1073741824;
      end else begin
        c  = $urandom;
        sn = $urandom;
      end
      sc = $urandom_range(0, 1) ? 34'($urandom_range(0, 268435456))
                                : {2'($urandom_range(0, 3)), 32'($urandom)};
      write_all(9'(win), phase == 3 ? 4'd2 : chans, c, sn, sc);
      mode  = $urandom_range(0, 3);
      nsets = (phase == 3) ? WIN_MAX : win * $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) nsets += $urandom_range(1, 3);
      for (int i = 0; i < nsets; i++) begin
        send_set(make_set(mode, ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(0, 9))));
        // Hold off once mid-stream until every phasor is out
        if (phase == 5 && i == nsets / 2) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (expected_phasors.size() != 0) @(posedge clk_i);
        end
      end
      drain();
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_WINDOW;
    cfg_data_i   = '0;
    mismatches   = 0;
    phasors_seen = 0;
    sets_sent    = 0;
    windows_closed = 0;
    no_gaps      = 1'b0;
    cycles       = 0;
    window_reg   = WINDOW_RST;
    chan_reg     = CHANNELS_RST;
    cos_reg      = COS_RST;
    sin_reg      = SIN_RST;
    scale_reg    = SCALE_RST;
    position     = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      recent_acc[i] = 0;
      older_acc[i]  = 0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_window_of_one();
    test_register_limits();
    test_window_cut_short();
    test_random_windows();
    drain();

    $display("covered %0d sample sets, %0d windows closed, %0d phasors checked",
             sets_sent, windows_closed, phasors_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && expected_phasors.size() == 0) begin
      $display("PASS goertzel_phasor_estimator");
    end else begin
      $display("FAIL goertzel_phasor_estimator");
    end
    $finish;
  end

endmodule

>>> sim.f
src/gpe_pkg.sv
src/gpe_mul.sv
src/gpe_isqrt.sv
src/gpe_cordic.sv
src/goertzel_phasor_estimator.sv
src/gpe_checker.sv
tb/tb_goertzel_phasor_estimator.sv
